/* hw/rtl/crzm_pkg.sv */
// Package for the crop and 2x zoom block: sizes, register map and the
// rounded mean helper. No dependencies.
`default_nettype none

package crzm_pkg;

   localparam int MAX_CROP   = 1024;
   localparam int MAX_WIDTH  = 4096;

   localparam int PIX_W      = 8;
   localparam int COUNT_W    = $clog2(MAX_WIDTH);     // row / column counters
   localparam int IDX_W      = $clog2(MAX_CROP);      // crop row store index
   localparam int COORD_W    = 11;
   localparam int WIDTH_W    = 13;
   localparam int SIZE_W     = 11;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   // register word index (byte address / 4)
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH = 2'd0,
      REG_CROP_TOP    = 2'd1,
      REG_CROP_LEFT   = 2'd2,
      REG_CROP_SIZE   = 2'd3
   } reg_index_type;

   localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = WIDTH_W'(640);
   localparam logic [SIZE_W-1:0]  CROP_SIZE_RESET   = SIZE_W'(16);
   localparam logic [SIZE_W-1:0]  MAX_CROP_SIZE     = SIZE_W'(MAX_CROP);

   // pending result slots of one crop pixel, emitted centre, up, left, self
   typedef struct packed {
      logic self_pt;
      logic left_pt;
      logic up_pt;
      logic centre_pt;
   } slot_mask_type;

   function automatic logic [PIX_W-1:0] mean2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      logic [PIX_W:0] sum;
      sum   = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
      mean2 = sum[PIX_W:1];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/crop_zoom_2x_interpolate_top.sv */
// Crop and 2x zoom by rounded-mean interpolation, streamed in raster order.
// An input beat passes through stage 1, stage 2 and the result beat register
// before its first result beat. Throughput: one result beat per cycle while
// rsp_tready holds; a crop pixel gives 1 to 4 results, pixels outside the
// crop give none. The result emitter is the limit. Synchronous active-high
// reset: counters, neighbour pixels, pipeline valids and registers to reset
// values; row store uncleared. Depends on crzm_pkg.
`default_nettype none

module crop_zoom_2x_interpolate_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] pixel
   input  wire logic        req_tuser,   // [0] frame_start
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [10:0] out_row, [21:11] out_col,
                                         // [29:22] value, [31:30] zero
   output logic             rsp_tlast,   // last result of the input pixel
   output logic             rsp_tuser,   // [0] frame_done
   // configuration
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [crzm_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [crzm_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [crzm_pkg::DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int PW = crzm_pkg::PIX_W;
   localparam int CW = crzm_pkg::COUNT_W;
   localparam int IW = crzm_pkg::IDX_W;
   localparam int OW = crzm_pkg::COORD_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [crzm_pkg::WIDTH_W-1:0] image_width_ff, image_width_in;
   logic [CW-1:0]                crop_top_ff, crop_top_in;
   logic [CW-1:0]                crop_left_ff, crop_left_in;
   logic [crzm_pkg::SIZE_W-1:0]  crop_size_ff, crop_size_in;

   crzm_pkg::reg_index_type csr_index;
   logic                    csr_write;

   assign csr_index  = crzm_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      image_width_in = image_width_ff;
      crop_top_in    = crop_top_ff;
      crop_left_in   = crop_left_ff;
      crop_size_in   = crop_size_ff;
      if (csr_write) begin
         case (csr_index)
            crzm_pkg::REG_IMAGE_WIDTH: image_width_in = csr_pwdata[crzm_pkg::WIDTH_W-1:0];
            crzm_pkg::REG_CROP_TOP:    crop_top_in    = csr_pwdata[CW-1:0];
            crzm_pkg::REG_CROP_LEFT:   crop_left_in   = csr_pwdata[CW-1:0];
            crzm_pkg::REG_CROP_SIZE:   crop_size_in   = csr_pwdata[crzm_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         crzm_pkg::REG_IMAGE_WIDTH: csr_prdata = 32'(image_width_ff);
         crzm_pkg::REG_CROP_TOP:    csr_prdata = 32'(crop_top_ff);
         crzm_pkg::REG_CROP_LEFT:   csr_prdata = 32'(crop_left_ff);
         crzm_pkg::REG_CROP_SIZE:   csr_prdata = 32'(crop_size_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline registers
   //   s1: in-crop pixel, row store read in flight
   //   s2: emitter, holds the up-to-four results of one crop pixel
   //   out: result beat register
   // ------------------------------------------------------------------
   logic [CW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] col_count_ff, col_count_in;
   logic [PW-1:0] left_pixel_ff, left_pixel_in;
   logic [PW-1:0] upper_left_ff, upper_left_in;

   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_pixel_ff, s1_pixel_in;
   logic [IW-1:0] s1_i_ff, s1_i_in;
   logic [IW-1:0] s1_j_ff, s1_j_in;
   logic          s1_done_ff, s1_done_in;     // bottom right crop pixel
   logic          s1_fwd_ff, s1_fwd_in;       // row store entry written same edge
   logic [PW-1:0] s1_fwd_data_ff, s1_fwd_data_in;

   logic                   s2_valid_ff, s2_valid_in;
   crzm_pkg::slot_mask_type s2_mask_ff, s2_mask_in;
   logic [IW-1:0]          s2_i_ff, s2_i_in;
   logic [IW-1:0]          s2_j_ff, s2_j_in;
   logic                   s2_done_ff, s2_done_in;
   logic [PW-1:0]          s2_vc_ff, s2_vc_in;
   logic [PW-1:0]          s2_vu_ff, s2_vu_in;
   logic [PW-1:0]          s2_vl_ff, s2_vl_in;
   logic [PW-1:0]          s2_vp_ff, s2_vp_in;

   logic          out_valid_ff, out_valid_in;
   logic [OW-1:0] out_row_ff, out_row_in;
   logic [OW-1:0] out_col_ff, out_col_in;
   logic [PW-1:0] out_value_ff, out_value_in;
   logic          out_last_ff, out_last_in;
   logic          out_fdone_ff, out_fdone_in;

   // row store: entry j holds crop pixel (i-1, j) until (i, j) replaces it
   logic [PW-1:0] row_mem [crzm_pkg::MAX_CROP];
   logic [PW-1:0] mem_rd_ff;

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   logic push, s2_finish, s1_move, accept;
   crzm_pkg::slot_mask_type sel, rest;

   always_comb begin
      // first pending slot in emission order
      sel = '0;
      if (s2_mask_ff.centre_pt)    sel.centre_pt = 1'b1;
      else if (s2_mask_ff.up_pt)   sel.up_pt     = 1'b1;
      else if (s2_mask_ff.left_pt) sel.left_pt   = 1'b1;
      else                         sel.self_pt   = s2_mask_ff.self_pt;
      rest = s2_mask_ff & ~sel;
   end

   assign push       = s2_valid_ff && (!out_valid_ff || rsp_tready);
   assign s2_finish  = push && (rest == '0);
   assign s1_move    = s1_valid_ff && (!s2_valid_ff || s2_finish);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // Position tracking and crop test on the accepted beat
   // ------------------------------------------------------------------
   logic [CW-1:0]               row, col, di, dj;
   logic [CW:0]                 col_next;
   logic [crzm_pkg::SIZE_W-1:0] n_eff;
   logic                        in_crop;

   always_comb begin
      row      = req_tuser ? '0 : row_count_ff;
      col      = req_tuser ? '0 : col_count_ff;
      col_next = {1'b0, col} + (CW+1)'(1);
      n_eff    = (crop_size_ff > crzm_pkg::MAX_CROP_SIZE) ? crzm_pkg::MAX_CROP_SIZE
                                                          : crop_size_ff;
      di       = row - crop_top_ff;
      dj       = col - crop_left_ff;
      in_crop  = (row >= crop_top_ff) && (col >= crop_left_ff) &&
                 ({1'b0, di} < (CW+1)'(n_eff)) && ({1'b0, dj} < (CW+1)'(n_eff));
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (accept) begin
         if (col_next >= (CW+1)'(image_width_ff)) begin
            col_count_in = '0;
            row_count_in = row + CW'(1);
         end else begin
            col_count_in = col_next[CW-1:0];
            row_count_in = row;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1
   // ------------------------------------------------------------------
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_pixel_in    = s1_pixel_ff;
      s1_i_in        = s1_i_ff;
      s1_j_in        = s1_j_ff;
      s1_done_in     = s1_done_ff;
      s1_fwd_in      = s1_fwd_ff;
      s1_fwd_data_in = s1_fwd_data_ff;
      if (s1_move) s1_valid_in = 1'b0;
      if (accept && in_crop) begin
         s1_valid_in    = 1'b1;
         s1_pixel_in    = req_tdata;
         s1_i_in        = di[IW-1:0];
         s1_j_in        = dj[IW-1:0];
         s1_done_in     = ({1'b0, di} == (CW+1)'(n_eff - crzm_pkg::SIZE_W'(1))) &&
                          ({1'b0, dj} == (CW+1)'(n_eff - crzm_pkg::SIZE_W'(1)));
         // row store write of the leaving pixel lands on the same edge
         s1_fwd_in      = s1_move && (s1_j_ff == dj[IW-1:0]);
         s1_fwd_data_in = s1_pixel_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2 load: interpolate against the neighbours
   // ------------------------------------------------------------------
   logic [PW-1:0] up_pix, mid_up, mid_row;

   always_comb begin
      up_pix  = s1_fwd_ff ? s1_fwd_data_ff : mem_rd_ff;
      mid_up  = crzm_pkg::mean2(upper_left_ff, up_pix);
      mid_row = crzm_pkg::mean2(left_pixel_ff, s1_pixel_ff);
   end

   always_comb begin
      s2_valid_in   = s2_valid_ff;
      s2_mask_in    = s2_mask_ff;
      s2_i_in       = s2_i_ff;
      s2_j_in       = s2_j_ff;
      s2_done_in    = s2_done_ff;
      s2_vc_in      = s2_vc_ff;
      s2_vu_in      = s2_vu_ff;
      s2_vl_in      = s2_vl_ff;
      s2_vp_in      = s2_vp_ff;
      left_pixel_in = left_pixel_ff;
      upper_left_in = upper_left_ff;
      if (push) begin
         s2_mask_in  = rest;
         s2_valid_in = (rest != '0);
      end
      if (s1_move) begin
         s2_valid_in         = 1'b1;
         s2_mask_in.centre_pt = (s1_i_ff != '0) && (s1_j_ff != '0);
         s2_mask_in.up_pt     = (s1_i_ff != '0);
         s2_mask_in.left_pt   = (s1_j_ff != '0);
         s2_mask_in.self_pt   = 1'b1;
         s2_i_in       = s1_i_ff;
         s2_j_in       = s1_j_ff;
         s2_done_in    = s1_done_ff;
         s2_vc_in      = crzm_pkg::mean2(mid_up, mid_row);
         s2_vu_in      = crzm_pkg::mean2(up_pix, s1_pixel_ff);
         s2_vl_in      = mid_row;
         s2_vp_in      = s1_pixel_ff;
         left_pixel_in = s1_pixel_ff;
         upper_left_in = up_pix;
      end
   end

   // ------------------------------------------------------------------
   // Result beat register
   // ------------------------------------------------------------------
   logic [OW-1:0] even_row, even_col;

   assign even_row = {s2_i_ff, 1'b0};
   assign even_col = {s2_j_ff, 1'b0};

   always_comb begin
      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_fdone_in = out_fdone_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (push) begin
         out_valid_in = 1'b1;
         out_last_in  = (rest == '0);
         out_fdone_in = sel.self_pt && s2_done_ff;
         out_row_in   = (sel.centre_pt || sel.up_pt) ? even_row - OW'(1) : even_row;
         out_col_in   = (sel.centre_pt || sel.left_pt) ? even_col - OW'(1) : even_col;
         if (sel.centre_pt)    out_value_in = s2_vc_ff;
         else if (sel.up_pt)   out_value_in = s2_vu_ff;
         else if (sel.left_pt) out_value_in = s2_vl_ff;
         else                  out_value_in = s2_vp_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_value_ff, out_col_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_fdone_ff;

   // ------------------------------------------------------------------
   // Row store: read on an accepted in-crop beat, write when the pixel leaves stage 1
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept && in_crop) mem_rd_ff <= row_mem[dj[IW-1:0]];
      if (s1_move) row_mem[s1_j_ff] <= s1_pixel_ff;
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= crzm_pkg::IMAGE_WIDTH_RESET;
         crop_top_ff    <= '0;
         crop_left_ff   <= '0;
         crop_size_ff   <= crzm_pkg::CROP_SIZE_RESET;
         row_count_ff   <= '0;
         col_count_ff   <= '0;
         left_pixel_ff  <= '0;
         upper_left_ff  <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s2_mask_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         image_width_ff <= image_width_in;
         crop_top_ff    <= crop_top_in;
         crop_left_ff   <= crop_left_in;
         crop_size_ff   <= crop_size_in;
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         left_pixel_ff  <= left_pixel_in;
         upper_left_ff  <= upper_left_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         s2_mask_ff     <= s2_mask_in;
         out_valid_ff   <= out_valid_in;
      end
      s1_pixel_ff    <= s1_pixel_in;
      s1_i_ff        <= s1_i_in;
      s1_j_ff        <= s1_j_in;
      s1_done_ff     <= s1_done_in;
      s1_fwd_ff      <= s1_fwd_in;
      s1_fwd_data_ff <= s1_fwd_data_in;
      s2_i_ff        <= s2_i_in;
      s2_j_ff        <= s2_j_in;
      s2_done_ff     <= s2_done_in;
      s2_vc_ff       <= s2_vc_in;
      s2_vu_ff       <= s2_vu_in;
      s2_vl_ff       <= s2_vl_in;
      s2_vp_ff       <= s2_vp_in;
      out_row_ff     <= out_row_in;
      out_col_ff     <= out_col_in;
      out_value_ff   <= out_value_in;
      out_last_ff    <= out_last_in;
      out_fdone_ff   <= out_fdone_in;
   end

endmodule

`default_nettype wire
